// ===== hdl/ecal_pkg.sv =====
// Package for the seconds-to-calendar converter: shared types, constants and tables.
// Used by ecal_year and epoch_seconds_to_calendar; depends on nothing.
`default_nettype none

package ecal_pkg;

    localparam logic [31:0] DAY_DIV_INIT  = 32'd2831155200;  // 86400 shifted left by 15
    localparam logic [31:0] HOUR_DIV_INIT = 32'd57600;       // 3600 shifted left by 4
    localparam logic [31:0] MIN_DIV_INIT  = 32'd1920;        // 60 shifted left by 5
    localparam logic [31:0] WDAY_DIV_INIT = 32'd224;         // 7 shifted left by 5

    localparam logic [3:0] DAY_STEPS  = 4'd15;
    localparam logic [3:0] HOUR_STEPS = 4'd4;
    localparam logic [3:0] MIN_STEPS  = 4'd5;
    localparam logic [3:0] WDAY_STEPS = 4'd5;

    localparam logic [31:0] DAYS_PER_YEAR = 32'd365;
    localparam logic [31:0] DAYS_PER_LEAP = 32'd366;

    localparam logic [11:0] BASE_YEAR     = 12'd1970;
    localparam logic [11:0] CENTURY_BASE  = 12'd1900;
    localparam logic [11:0] LATE_BASE     = 12'd2000;
    localparam logic [11:0] LATE_CENTURY  = 12'd2100;
    localparam logic [1:0]  BASE_MOD4     = 2'd2;
    localparam logic [6:0]  BASE_MOD100   = 7'd70;
    localparam logic [8:0]  BASE_MOD400   = 9'd370;
    localparam logic [6:0]  LAST_MOD100   = 7'd99;
    localparam logic [8:0]  LAST_MOD400   = 9'd399;

    localparam logic [3:0] MONTH_FEB  = 4'd1;
    localparam logic [3:0] MONTH_MAR  = 4'd3;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    typedef struct packed {
        logic load;
        logic inc;
    } t_year_ctl;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
            4'd3, 4'd5, 4'd8, 4'd10:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] week_offset(input logic [3:0] m);
        logic [2:0] off;
        unique case (m)
            4'd0:    off = 3'd0;
            4'd1:    off = 3'd3;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd6;
            4'd4:    off = 3'd1;
            4'd5:    off = 3'd4;
            4'd6:    off = 3'd6;
            4'd7:    off = 3'd2;
            4'd8:    off = 3'd5;
            4'd9:    off = 3'd0;
            4'd10:   off = 3'd3;
            4'd11:   off = 3'd5;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ecal_sub.sv =====
// Shared 32-bit compare-and-subtract unit used by every division and walk step.
// Purely combinational; no package dependencies.
`default_nettype none

module ecal_sub (
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_ge,
    output logic [31:0]      o_diff
);

    logic [32:0] w_res;

    assign w_res  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_res[32];
    assign o_diff = w_res[31:0];

endmodule

`default_nettype wire

// ===== hdl/ecal_year.sv =====
// Year counter for the year walk, with running residues modulo 4, 100 and 400.
// Produces the Gregorian leap flag without any division; uses ecal_pkg.
`default_nettype none

module ecal_year
    import ecal_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_year_ctl   i_ctl,
    output logic [11:0]      o_year,
    output logic             o_leap
);

    logic [11:0] r_year;
    logic [1:0]  r_m4;
    logic [6:0]  r_m100;
    logic [8:0]  r_m400;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_year <= BASE_YEAR;
            r_m4   <= BASE_MOD4;
            r_m100 <= BASE_MOD100;
            r_m400 <= BASE_MOD400;
        end else if (i_ctl.inc) begin
            r_year <= r_year + 12'd1;
            r_m4   <= r_m4 + 2'd1;
            r_m100 <= (r_m100 == LAST_MOD100) ? 7'd0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == LAST_MOD400) ? 9'd0 : r_m400 + 9'd1;
        end
    end

    assign o_year = r_year;
    assign o_leap = (r_m4 == 2'd0) && ((r_m100 != 7'd0) || (r_m400 == 9'd0));

endmodule

`default_nettype wire

// ===== hdl/epoch_seconds_to_calendar.sv =====
// Top level of the seconds-to-calendar converter: sequencer, cache and output register.
// Depends on ecal_pkg, ecal_sub and ecal_year.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+--------------------------------------------
//   input   | i_in_valid / o_in_ready   | i_seconds_count
//   output  | o_out_valid / i_out_ready | o_year o_month o_day_of_month o_hour
//           |                           | o_minute o_second o_weekday
//
// A beat whose day matches the cached date skips the year and month walks; otherwise the
// date is recomputed by walking years from 1970 and then months of the found year.
// All steps run through the single compare-and-subtract unit.
// Reset clears the sequencer, the cache and the output valid flag.
// A stalled output beat holds the block in its final state until it is taken.
`default_nettype none

module epoch_seconds_to_calendar
    import ecal_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_seconds_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [11:0]      o_year,
    output logic [3:0]       o_month,
    output logic [4:0]       o_day_of_month,
    output logic [4:0]       o_hour,
    output logic [5:0]       o_minute,
    output logic [5:0]       o_second,
    output logic [2:0]       o_weekday
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DDIV  = 9'b000000010,
        S_HDIV  = 9'b000000100,
        S_MDIV  = 9'b000001000,
        S_YEAR  = 9'b000010000,
        S_MONTH = 9'b000100000,
        S_WSET  = 9'b001000000,
        S_WDAY  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_div, n_div;
    logic [15:0] r_quo, n_quo;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_days, n_days;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [3:0]  r_mon, n_mon;

    logic        r_cache_valid, n_cache_valid;
    logic [15:0] r_cday, n_cday;
    logic [11:0] r_cyear, n_cyear;
    logic [3:0]  r_cmon, n_cmon;
    logic [4:0]  r_cdate, n_cdate;

    logic        r_out_valid, n_out_valid;
    logic        n_load_out;

    logic [31:0] w_sub_b;
    logic        w_ge;
    logic [31:0] w_diff;
    logic [31:0] w_step_rem;
    logic [15:0] w_step_quo;
    t_year_ctl   w_yr_ctl;
    logic [11:0] w_yr;
    logic        w_leap;
    logic [7:0]  w_lo;
    logic        w_adj;
    logic [9:0]  w_wsum;

    ecal_sub u_sub (
        .i_a    (r_rem),
        .i_b    (w_sub_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    ecal_year u_year (
        .i_clk  (i_clk),
        .i_ctl  (w_yr_ctl),
        .o_year (w_yr),
        .o_leap (w_leap)
    );

    always_comb begin
        unique case (r_state)
            S_YEAR:  w_sub_b = w_leap ? DAYS_PER_LEAP : DAYS_PER_YEAR;
            S_MONTH: w_sub_b = {27'd0, month_len(r_mon, w_leap)};
            default: w_sub_b = r_div;
        endcase
    end

    assign w_step_rem = w_ge ? w_diff : r_rem;
    assign w_step_quo = {r_quo[14:0], w_ge};

    assign w_lo   = (r_cyear >= LATE_CENTURY) ? 8'(r_cyear - LATE_BASE)
                                              : 8'(r_cyear - CENTURY_BASE);
    assign w_adj  = (r_cyear[1:0] == 2'd0) && (r_cmon < MONTH_MAR);
    assign w_wsum = {2'd0, w_lo} + {4'd0, w_lo[7:2]} + {5'd0, r_cdate}
                  + {7'd0, week_offset(r_cmon - 4'd1)} - {9'd0, w_adj};

    always_comb begin
        n_state       = r_state;
        n_rem         = r_rem;
        n_div         = r_div;
        n_quo         = r_quo;
        n_cnt         = r_cnt;
        n_days        = r_days;
        n_hour        = r_hour;
        n_min         = r_min;
        n_sec         = r_sec;
        n_mon         = r_mon;
        n_cache_valid = r_cache_valid;
        n_cday        = r_cday;
        n_cyear       = r_cyear;
        n_cmon        = r_cmon;
        n_cdate       = r_cdate;
        n_load_out    = 1'b0;
        n_out_valid   = r_out_valid & ~i_out_ready;
        w_yr_ctl      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rem   = i_seconds_count;
                    n_div   = DAY_DIV_INIT;
                    n_cnt   = DAY_STEPS;
                    n_state = S_DDIV;
                end
            end
            S_DDIV: begin
                n_rem = w_step_rem;
                n_quo = w_step_quo;
                n_div = r_div >> 1;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_days  = w_step_quo;
                    n_div   = HOUR_DIV_INIT;
                    n_cnt   = HOUR_STEPS;
                    n_state = S_HDIV;
                end
            end
            S_HDIV: begin
                n_rem = w_step_rem;
                n_quo = w_step_quo;
                n_div = r_div >> 1;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_hour  = w_step_quo[4:0];
                    n_div   = MIN_DIV_INIT;
                    n_cnt   = MIN_STEPS;
                    n_state = S_MDIV;
                end
            end
            S_MDIV: begin
                n_rem = w_step_rem;
                n_quo = w_step_quo;
                n_div = r_div >> 1;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_min = w_step_quo[5:0];
                    n_sec = w_step_rem[5:0];
                    if (!r_cache_valid || (r_cday != r_days)) begin
                        n_rem         = {16'd0, r_days};
                        w_yr_ctl.load = 1'b1;
                        n_state       = S_YEAR;
                    end else begin
                        n_state = S_WSET;
                    end
                end
            end
            S_YEAR: begin
                if (w_ge) begin
                    n_rem        = w_diff;
                    w_yr_ctl.inc = 1'b1;
                end else begin
                    n_mon   = 4'd0;
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                if (w_ge && (r_mon != MONTH_LAST)) begin
                    n_rem = w_diff;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_cache_valid = 1'b1;
                    n_cday        = r_days;
                    n_cyear       = w_yr;
                    n_cmon        = r_mon + 4'd1;
                    n_cdate       = r_rem[4:0] + 5'd1;
                    n_state       = S_WSET;
                end
            end
            S_WSET: begin
                n_rem   = {22'd0, w_wsum};
                n_div   = WDAY_DIV_INIT;
                n_cnt   = WDAY_STEPS;
                n_state = S_WDAY;
            end
            S_WDAY: begin
                n_rem = w_step_rem;
                n_div = r_div >> 1;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_cache_valid <= 1'b0;
            r_cday        <= '0;
            r_cyear       <= '0;
            r_cmon        <= '0;
            r_cdate       <= '0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_cache_valid <= n_cache_valid;
            r_cday        <= n_cday;
            r_cyear       <= n_cyear;
            r_cmon        <= n_cmon;
            r_cdate       <= n_cdate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_mon  <= n_mon;
    end

    always_ff @(posedge i_clk) begin
        if (n_load_out) begin
            o_year         <= r_cyear;
            o_month        <= r_cmon;
            o_day_of_month <= r_cdate;
            o_hour         <= r_hour;
            o_minute       <= r_min;
            o_second       <= r_sec;
            o_weekday      <= r_rem[2:0];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_wday_cache_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WSET) |-> r_cache_valid)
        else $error("Weekday setup started without a valid cached date.");

    a_year_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR) |-> (w_yr <= 12'd2106))
        else $error("Year walk ran past the largest representable year.");

    a_out_date_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month >= 5'd1))
        else $error("Output beat carries an impossible month or day.");

    a_out_time_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second <= 6'd59)
            && (o_weekday <= 3'd6))
        else $error("Output beat carries an impossible time or weekday.");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/epoch_seconds_to_calendar_tb.sv =====
// Self-checking testbench for epoch_seconds_to_calendar: drives second counts, predicts
// the calendar date, time and weekday of each beat and compares every output beat.
// Depends only on the RTL of the converter.
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_tb;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned FIRST_YEAR    = 1970;
    localparam int unsigned LAST_DAY      = 49710;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES  = 200;
    localparam int unsigned PHASE_BEATS   = 425;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned WEEK_SHIFT [12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } t_calendar;

    class calendar_scoreboard;
        t_calendar   expected_q[$];
        logic [15:0] cached_day;
        bit          cache_ok;
        logic [11:0] cached_year;
        logic [3:0]  cached_month;
        logic [4:0]  cached_mday;
        int          errors;

        function new();
            cached_day   = '0;
            cache_ok     = 1'b0;
            cached_year  = '0;
            cached_month = '0;
            cached_mday  = '0;
            errors       = 0;
        endfunction

        function bit is_leap(int unsigned y);
            if (y % 4 != 0) return 1'b0;
            if (y % 100 != 0) return 1'b1;
            return (y % 400) == 0;
        endfunction

        function void note_seconds(logic [31:0] secs);
            int unsigned days, rem, left, y, m, len, lo, t;
            t_calendar   cal;
            days = secs / SECS_PER_DAY;
            rem  = secs % SECS_PER_DAY;
            if (!cache_ok || cached_day != days[15:0]) begin
                cached_day = days[15:0];
                cache_ok   = 1'b1;
                left = days;
                y    = FIRST_YEAR;
                while (left >= (is_leap(y) ? 366 : 365)) begin
                    left -= is_leap(y) ? 366 : 365;
                    y++;
                end
                m = 0;
                while (m < 11) begin
                    len = MONTH_DAYS[m];
                    if (m == 1 && is_leap(y)) len = 29;
                    if (left < len) break;
                    left -= len;
                    m++;
                end
                cached_year  = y[11:0];
                cached_month = 4'(m + 1);
                cached_mday  = 5'(left + 1);
            end
            // The table formula treats every year divisible by four as leap, 2100 included.
            lo = cached_year % 100;
            if (cached_year / 100 > 19) lo += 100;
            t = (lo + lo / 4) % 7;
            t = t + cached_mday + WEEK_SHIFT[(cached_month - 1) % 12];
            if (lo % 4 == 0 && cached_month < 3 && t > 0) t--;
            cal.year    = cached_year;
            cal.month   = cached_month;
            cal.mday    = cached_mday;
            cal.hour    = 5'(rem / SECS_PER_HOUR);
            cal.minute  = 6'((rem % SECS_PER_HOUR) / 60);
            cal.second  = 6'(rem % 60);
            cal.weekday = 3'(t % 7);
            expected_q.push_back(cal);
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_calendar(t_calendar got);
            t_calendar want;
            if (expected_q.size() == 0) begin
                $error("Output beat with no pending input: year %0d", got.year);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("year", want.year, got.year);
            compare_field("month", want.month, got.month);
            compare_field("day_of_month", want.mday, got.mday);
            compare_field("hour", want.hour, got.hour);
            compare_field("minute", want.minute, got.minute);
            compare_field("second", want.second, got.second);
            compare_field("weekday", want.weekday, got.weekday);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_seconds_count;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day_of_month;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic [2:0]  o_weekday;

    calendar_scoreboard sb = new();
    int unsigned        src_idle_pct;
    int unsigned        sink_stall_pct;
    int unsigned        quiet_cycles = 0;
    logic [31:0]        last_secs;

    epoch_seconds_to_calendar uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_seconds_count (i_seconds_count),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_calendar('{o_year, o_month, o_day_of_month, o_hour, o_minute,
                                    o_second, o_weekday});
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_seconds(i_seconds_count);
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_seconds(input logic [31:0] secs);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_seconds_count <= secs;
        last_secs        = secs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned beats, input int unsigned idle_pct,
                             input int unsigned stall_pct);
        int unsigned kind;
        longint      stamp;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (beats) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                stamp = $urandom;
            end else if (kind < 60) begin
                stamp = longint'(last_secs / SECS_PER_DAY) * SECS_PER_DAY
                        + $urandom_range(SECS_PER_DAY - 1);
            end else if (kind < 78) begin
                stamp = longint'($urandom_range(LAST_DAY - 1)) * SECS_PER_DAY;
                if ($urandom_range(1)) begin
                    stamp += $urandom_range(59);
                end else begin
                    stamp += SECS_PER_DAY - 1 - $urandom_range(59);
                end
            end else if (kind < 90) begin
                stamp = $urandom_range(32'hFFFF_FFFF, 32'd4070908800);
            end else begin
                stamp = $urandom_range(3 * 366 * SECS_PER_DAY);
            end
            if (stamp > 64'hFFFF_FFFF) stamp = 64'hFFFF_FFFF;
            send_seconds(stamp[31:0]);
        end
    endtask

    initial begin
        logic [31:0] corner_secs [23];
        corner_secs = '{32'd0, 32'd59, 32'd3599, 32'd86399, 32'd86400, 32'd0,
                        32'd31535999, 32'd31536000, 32'd68169600, 32'd126144000,
                        32'd126230399, 32'd126230400, 32'd951782400, 32'd951868800,
                        32'd978220800, 32'd4102444799, 32'd4102444800, 32'd4107456000,
                        32'd4107542400, 32'd4294944000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                        32'h5555_5555};
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        last_secs        = '0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_seconds_count <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first beat after reset is day zero, which must not hit the cleared cache.
        foreach (corner_secs[k]) send_seconds(corner_secs[k]);

        run_phase(PHASE_BEATS, 0, 0);
        run_phase(PHASE_BEATS, 74, 0);
        run_phase(PHASE_BEATS, 0, 74);
        run_phase(PHASE_BEATS, 30, 30);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
